// ===== sv/line_k_median_partition_dp_assert.svh =====
// Assertion macros for the line k-median partition block
`ifndef LINE_K_MEDIAN_PARTITION_DP_ASSERT_SVH
`define LINE_K_MEDIAN_PARTITION_DP_ASSERT_SVH

// never both in the same cycle
`define LKM_ASSERT_NEVER(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) \
		else $error("lkm: exclusive signals both high");

// next-cycle implication
`define LKM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lkm: next-cycle check failed");

`endif

// ===== sv/lkm_pkg.sv =====
// ----------------------------------------------------------------------------
// lkm_pkg
// Shared types and constants of the line k-median partition block.
// ----------------------------------------------------------------------------
`default_nettype none
package lkm_pkg;

	localparam int MAX_VILLAGES = 256;
	localparam int MAX_OFFICES  = 32;
	localparam int POS_BITS     = 16;
	localparam int BEST_COLS    = MAX_OFFICES + 1;
	localparam int IDX_W        = $clog2(MAX_VILLAGES);
	localparam int CNT_W        = IDX_W + 1;
	localparam int KW           = 6;
	localparam int SUM_W        = 24;
	localparam int BEST_W       = 25;
	localparam int RC_AW        = 2 * IDX_W;
	localparam int BC_AW        = $clog2(MAX_VILLAGES * BEST_COLS);

	typedef struct packed {
		logic [15:0] position;
		logic        last;
	} in_item_t;

	typedef struct packed {
		logic [23:0] total_distance;
		logic        overflow;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic init;
		logic med_rd;
		logic med_cap;
		logic sum_rd;
		logic sum_acc;
		logic rc_wr;
		logic dp_init;
		logic dp_start;
		logic j1_cap;
		logic m_rd;
		logic m_acc;
		logic dp_wr;
		logic out_take;
	} lkm_cmd_t;

	typedef struct packed {
		logic k_ge_n;
		logic t_end;
		logic a_end;
		logic b_end;
		logic j_one;
		logic j_diag;
		logic m_end;
		logic j_end;
		logic i_end;
	} lkm_status_t;

endpackage
`default_nettype wire

// ===== sv/lkm_ctrl.sv =====
// ----------------------------------------------------------------------------
// lkm_ctrl
// Sequencer for loading, range cost build and partition programme.
// ----------------------------------------------------------------------------
`default_nettype none
module lkm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	input  wire                  in_last,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  lkm_pkg::lkm_status_t sts,
	output lkm_pkg::lkm_cmd_t    cmd
);
	import lkm_pkg::*;

	localparam logic [3:0] S_LOAD    = 4'd0;
	localparam logic [3:0] S_INIT    = 4'd1;
	localparam logic [3:0] S_MED_RD  = 4'd2;
	localparam logic [3:0] S_MED_CAP = 4'd3;
	localparam logic [3:0] S_SUM_RD  = 4'd4;
	localparam logic [3:0] S_SUM_ACC = 4'd5;
	localparam logic [3:0] S_RC_WR   = 4'd6;
	localparam logic [3:0] S_DP_J    = 4'd7;
	localparam logic [3:0] S_DP_J1   = 4'd8;
	localparam logic [3:0] S_M_RD    = 4'd9;
	localparam logic [3:0] S_M_ACC   = 4'd10;
	localparam logic [3:0] S_DP_WR   = 4'd11;
	localparam logic [3:0] S_OUT     = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready  = (state_q == S_LOAD);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) state_d = S_INIT;
				end
			end
			S_INIT: begin
				cmd.init = 1'b1;
				state_d  = sts.k_ge_n ? S_OUT : S_MED_RD;
			end
			S_MED_RD: begin
				cmd.med_rd = 1'b1;
				state_d    = S_MED_CAP;
			end
			S_MED_CAP: begin
				cmd.med_cap = 1'b1;
				state_d     = S_SUM_RD;
			end
			S_SUM_RD: begin
				cmd.sum_rd = 1'b1;
				state_d    = S_SUM_ACC;
			end
			S_SUM_ACC: begin
				cmd.sum_acc = 1'b1;
				state_d     = sts.t_end ? S_RC_WR : S_SUM_RD;
			end
			S_RC_WR: begin
				cmd.rc_wr = 1'b1;
				if (sts.a_end && sts.b_end) begin
					cmd.dp_init = 1'b1;
					state_d     = S_DP_J;
				end else begin
					state_d = S_MED_RD;
				end
			end
			S_DP_J: begin
				cmd.dp_start = 1'b1;
				if (sts.j_one)       state_d = S_DP_J1;
				else if (sts.j_diag) state_d = S_DP_WR;
				else                 state_d = S_M_RD;
			end
			S_DP_J1: begin
				cmd.j1_cap = 1'b1;
				state_d    = S_DP_WR;
			end
			S_M_RD: begin
				cmd.m_rd = 1'b1;
				state_d  = S_M_ACC;
			end
			S_M_ACC: begin
				cmd.m_acc = 1'b1;
				state_d   = sts.m_end ? S_DP_WR : S_M_RD;
			end
			S_DP_WR: begin
				cmd.dp_wr = 1'b1;
				state_d   = (sts.j_end && sts.i_end) ? S_OUT : S_DP_J;
			end
			S_OUT: begin
				if (out_ready) begin
					cmd.out_take = 1'b1;
					state_d      = S_LOAD;
				end
			end
			default: state_d = S_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_LOAD;
		else         state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== sv/lkm_dp.sv =====
// ----------------------------------------------------------------------------
// lkm_dp
// Datapath: position store, range cost and best cost memories, counters.
// ----------------------------------------------------------------------------
`default_nettype none
module lkm_dp (
	input  wire                  clk,
	input  wire                  arst_n,
	input  lkm_pkg::in_item_t    in_data,
	input  wire                  cfg_we,
	input  wire [5:0]            cfg_data,
	input  lkm_pkg::lkm_cmd_t    cmd,
	output lkm_pkg::lkm_status_t sts,
	output lkm_pkg::out_item_t   out_data
);
	import lkm_pkg::*;

	logic [POS_BITS-1:0] pos_mem [MAX_VILLAGES];
	logic [SUM_W-1:0]    rc_mem  [MAX_VILLAGES*MAX_VILLAGES];
	logic [BEST_W-1:0]   bc_mem  [MAX_VILLAGES*BEST_COLS];

	logic [KW-1:0]       office_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                drop_q;
	logic [KW-1:0]       k_q;
	logic [IDX_W-1:0]    a_q, b_q, t_q, i_q, m_q;
	logic [KW-1:0]       j_q;
	logic [POS_BITS-1:0] med_q, pos_rd_q;
	logic [SUM_W-1:0]    sum_q, rc_rd_q;
	logic [BEST_W-1:0]   best_q, bc_rd_q;
	out_item_t           res_q;

	logic [KW-1:0]       k0;
	logic [CNT_W-1:0]    n_m1;
	logic [CNT_W-1:0]    mid_sum;
	logic [IDX_W-1:0]    med_idx;
	logic [POS_BITS-1:0] pos_diff;
	logic [BEST_W:0]     cand;
	logic [BC_AW-1:0]    bc_wa, bc_ra;
	logic [RC_AW-1:0]    rc_ra;
	logic [IDX_W-1:0]    m_p1;

	assign k0       = (office_q == '0) ? KW'(1) : office_q;
	assign n_m1     = cnt_q - CNT_W'(1);
	assign mid_sum  = {1'b0, a_q} + {1'b0, b_q};
	assign med_idx  = mid_sum[CNT_W-1:1];
	assign pos_diff = (pos_rd_q >= med_q) ? (pos_rd_q - med_q) : (med_q - pos_rd_q);
	assign cand     = {1'b0, bc_rd_q} + (BEST_W+1)'(rc_rd_q);
	assign m_p1     = m_q + IDX_W'(1);
	assign bc_wa    = BC_AW'({i_q, 5'b0}) + BC_AW'(i_q) + BC_AW'(j_q);
	assign bc_ra    = BC_AW'({m_q, 5'b0}) + BC_AW'(m_q) + BC_AW'(j_q - KW'(1));
	assign rc_ra    = cmd.m_rd ? {m_p1, i_q} : {IDX_W'(0), i_q};

	assign sts.k_ge_n = (CNT_W'(k0) >= cnt_q);
	assign sts.t_end  = (t_q == b_q);
	assign sts.a_end  = ({1'b0, a_q} == n_m1);
	assign sts.b_end  = ({1'b0, b_q} == n_m1);
	assign sts.j_one  = (j_q == KW'(1));
	assign sts.j_diag = (CNT_W'(j_q) == {1'b0, i_q} + CNT_W'(1));
	assign sts.m_end  = (m_p1 == i_q);
	assign sts.j_end  = (j_q == k_q) || sts.j_diag;
	assign sts.i_end  = ({1'b0, i_q} == n_m1);

	assign out_data = res_q;

	always_ff @(posedge clk) begin
		if (cmd.load && !cnt_q[CNT_W-1]) pos_mem[cnt_q[IDX_W-1:0]] <= in_data.position;
		if (cmd.med_rd) pos_rd_q <= pos_mem[med_idx];
		if (cmd.sum_rd) pos_rd_q <= pos_mem[t_q];
		if (cmd.rc_wr) rc_mem[{a_q, b_q}] <= sum_q;
		if (cmd.dp_start || cmd.m_rd) rc_rd_q <= rc_mem[rc_ra];
		if (cmd.dp_wr) bc_mem[bc_wa] <= best_q;
		if (cmd.m_rd) bc_rd_q <= bc_mem[bc_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.init) begin
			k_q <= (k0 > KW'(MAX_OFFICES)) ? KW'(MAX_OFFICES) : k0;
			a_q <= '0;
			b_q <= '0;
			if (sts.k_ge_n) begin
				res_q.total_distance <= '0;
				res_q.overflow       <= drop_q;
			end
		end
		if (cmd.med_cap) begin
			med_q <= pos_rd_q;
			t_q   <= a_q;
			sum_q <= '0;
		end
		if (cmd.sum_acc) begin
			sum_q <= sum_q + SUM_W'(pos_diff);
			t_q   <= t_q + IDX_W'(1);
		end
		if (cmd.rc_wr) begin
			if (sts.b_end) begin
				a_q <= a_q + IDX_W'(1);
				b_q <= a_q + IDX_W'(1);
			end else begin
				b_q <= b_q + IDX_W'(1);
			end
		end
		if (cmd.dp_init) begin
			i_q <= '0;
			j_q <= KW'(1);
		end
		if (cmd.dp_start) begin
			if (!sts.j_one && sts.j_diag) begin
				best_q <= '0;
			end else begin
				best_q <= '1;
				m_q    <= IDX_W'(j_q) - IDX_W'(2);
			end
		end
		if (cmd.j1_cap) best_q <= BEST_W'(rc_rd_q);
		if (cmd.m_acc) begin
			if (cand < {1'b0, best_q}) best_q <= cand[BEST_W-1:0];
			m_q <= m_p1;
		end
		if (cmd.dp_wr) begin
			if (sts.j_end) begin
				i_q <= i_q + IDX_W'(1);
				j_q <= KW'(1);
			end else begin
				j_q <= j_q + KW'(1);
			end
			if (sts.j_end && sts.i_end) begin
				res_q.total_distance <= best_q[BEST_W-1] ? '1 : best_q[SUM_W-1:0];
				res_q.overflow       <= drop_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			office_q <= KW'(1);
			cnt_q    <= '0;
			drop_q   <= 1'b0;
		end else begin
			if (cfg_we) office_q <= cfg_data;
			if (cmd.out_take) begin
				cnt_q  <= '0;
				drop_q <= 1'b0;
			end else if (cmd.load) begin
				if (cnt_q[CNT_W-1]) drop_q <= 1'b1;
				else                cnt_q  <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/line_k_median_partition_dp.sv =====
// ----------------------------------------------------------------------------
// line_k_median_partition_dp
// Least total distance of villages on a line to office_count offices.
//
//   channel | signals                       | transaction
//   in      | in_valid/in_ready/in_data     | one village position, last flag
//   out     | out_valid/out_ready/out_data  | total distance, overflow flag
//   cfg     | cfg_we/cfg_data               | office count write
//
// Loading accepts one village per cycle. After the last village, the range
// cost build reads each position from the single-port position store and
// adds its distance from the median, then the partition programme runs.
// Reset clears the village counter and drop flag and sets office count to 1.
// The result holds until taken; no new village is accepted meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
module line_k_median_partition_dp (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  lkm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output lkm_pkg::out_item_t out_data,
	input  wire                cfg_we,
	input  wire [5:0]          cfg_data
);
	import lkm_pkg::*;

	lkm_cmd_t    cmd;
	lkm_status_t sts;

	lkm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_last   (in_data.last),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lkm_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.out_data (out_data)
	);

`include "line_k_median_partition_dp_assert.svh"

	`LKM_ASSERT_NEVER(a_in_out_excl, clk, arst_n, in_ready, out_valid)
	`LKM_ASSERT_NEXT(a_out_then_load, clk, arst_n, out_valid && out_ready, in_ready)
	`LKM_ASSERT_NEXT(a_last_closes, clk, arst_n, in_valid && in_ready && in_data.last, !in_ready)

endmodule
`default_nettype wire

// ===== dv/line_k_median_partition_dp_tb.sv =====
// ----------------------------------------------------------------------------
// line_k_median_partition_dp_tb
// Self-checking bench for the line k-median partition block.
//
// Village sets, mostly small and sorted, some unsorted and one past capacity,
// are driven under several office counts with random gaps on both channels.
// A scoreboard rebuilds the range costs and the partition programme for each
// closed set and checks every result transaction against its prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module line_k_median_partition_dp_tb;
	import lkm_pkg::*;

	class distance_scoreboard;
		logic [15:0] village_pos[MAX_VILLAGES];
		int unsigned held;
		bit          dropped;
		logic [5:0]  offices;
		out_item_t   expected_q[$];
		int unsigned errors;
		longint      span[MAX_VILLAGES][MAX_VILLAGES];
		longint      part[MAX_VILLAGES][BEST_COLS];

		function new();
			held = 0;
			dropped = 0;
			offices = 1;
			errors = 0;
		endfunction

		function void set_offices(logic [5:0] v);
			offices = v;
		endfunction

		function longint min_distance();
			int unsigned n;
			int unsigned k;
			longint      med;
			longint      sum;
			longint      c;
			longint      best;
			n = held;
			k = (offices == 0) ? 1 : offices;
			if (k >= n)
				return 0;
			if (k > MAX_OFFICES)
				k = MAX_OFFICES;
			for (int a = 0; a < n; a++) begin
				for (int b = a; b < n; b++) begin
					med = village_pos[(a + b) / 2];
					sum = 0;
					for (int t = a; t <= b; t++)
						sum += (village_pos[t] >= med) ? village_pos[t] - med
							: med - village_pos[t];
					span[a][b] = sum;
				end
			end
			for (int i = 0; i < n; i++) begin
				for (int j = 1; j <= k && j <= i + 1; j++) begin
					if (j == 1) begin
						best = span[0][i];
					end else if (j == i + 1) begin
						best = 0;
					end else begin
						best = 64'h3FFF_FFFF_FFFF_FFFF;
						for (int m = j - 2; m < i; m++) begin
							c = part[m][j - 1] + span[m + 1][i];
							if (c < best)
								best = c;
						end
					end
					part[i][j] = best;
				end
			end
			return part[n - 1][k];
		endfunction

		function void note_village(in_item_t it);
			longint    total;
			out_item_t res;
			if (held < MAX_VILLAGES) begin
				village_pos[held] = it.position;
				held++;
			end else begin
				dropped = 1;
			end
			if (it.last) begin
				total = min_distance();
				if (total > 64'hFF_FFFF)
					total = 64'hFF_FFFF;
				res.total_distance = total[23:0];
				res.overflow = dropped;
				expected_q.push_back(res);
				held = 0;
				dropped = 0;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result transaction: total_distance %0d overflow %0d",
					got.total_distance, got.overflow);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.total_distance !== want.total_distance) begin
				$error("total_distance: expected %0d, actual %0d",
					want.total_distance, got.total_distance);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_ready;
	out_item_t  out_data;
	logic       cfg_we;
	logic [5:0] cfg_data;

	distance_scoreboard sb;
	int unsigned        villages_sent;
	int unsigned        hold_cycles;

	line_k_median_partition_dp u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	function automatic int unsigned idle_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);

	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready = 0;
		end else if (hold_cycles > 0) begin
			out_ready = 0;
			hold_cycles--;
		end else if ($urandom_range(0, 3) == 0) begin
			out_ready = 0;
			if ($urandom_range(0, 39) == 0)
				hold_cycles = $urandom_range(10, 40);
		end else begin
			out_ready = 1;
		end
	end

	task automatic send_village(logic [15:0] pos, logic last);
		int unsigned gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1;
		in_data.position = pos;
		in_data.last = last;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_village(in_data);
		villages_sent++;
		@(negedge clk);
	endtask

	task automatic send_set(logic [15:0] pos_q[$]);
		for (int i = 0; i < pos_q.size(); i++)
			send_village(pos_q[i], i == pos_q.size() - 1);
		in_valid = 0;
	endtask

	task automatic drain();
		in_valid = 0;
		while (sb.expected_q.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_offices(logic [5:0] v);
		drain();
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		sb.set_offices(v);
	endtask

	task automatic random_set(int unsigned n, bit sorted);
		logic [15:0] pos_q[$];
		int unsigned lo;
		int unsigned span_w;
		lo = $urandom_range(0, 65535);
		span_w = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(1, 300);
		for (int i = 0; i < n; i++) begin
			if (span_w == 65535)
				pos_q.push_back(16'($urandom_range(0, 65535)));
			else
				pos_q.push_back(16'(lo + $urandom_range(0, span_w)));
		end
		if (sorted)
			pos_q.sort();
		send_set(pos_q);
	endtask

	initial begin
		#500_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [5:0] office_plan[$];
		int unsigned n;
		sb = new();
		villages_sent = 0;
		hold_cycles = 0;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_ready = 0;
		cfg_we = 0;
		cfg_data = '0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: single village, extremes, duplicates, unsorted order
		send_set('{16'h1234});
		send_set('{16'h0000, 16'hFFFF});
		send_set('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
		write_offices(2);
		send_set('{16'h0000, 16'h5555, 16'hAAAA, 16'hFFFF, 16'hFFFF});
		send_set('{16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF});
		write_offices(0);
		send_set('{16'h0010, 16'h0020, 16'hF000});
		write_offices(63);
		send_set('{16'h0003, 16'h0300, 16'h3000});

		// fill up behind a long receiver hold-off
		write_offices(1);
		hold_cycles = 400;
		for (int s = 0; s < 4; s++)
			random_set(3, 1);

		// past capacity: last two villages dropped
		write_offices(2);
		random_set(MAX_VILLAGES + 2, 1);

		office_plan = '{32, 1, 3, 2, 31, 4, 0, 63, 5, 7, 33, 6};
		while (villages_sent < 1900) begin
			foreach (office_plan[p]) begin
				if (villages_sent >= 1900)
					break;
				write_offices(office_plan[p]);
				for (int s = 0; s < 12; s++) begin
					n = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 34)
						: $urandom_range(1, 10);
					random_set(n, $urandom_range(0, 9) != 0);
				end
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+sv
sv/lkm_pkg.sv
sv/lkm_ctrl.sv
sv/lkm_dp.sv
sv/line_k_median_partition_dp.sv
dv/line_k_median_partition_dp_tb.sv
